FILE: src/assert_macros.svh
// assertion helpers included by the rtl sequencer file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that must hold at every clock edge outside reset
`define ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// same-cycle implication
`define ASSERT_IMPLIES(label, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error(msg);

// next-cycle implication
`define ASSERT_NEXT(label, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error(msg);

`endif

FILE: src/prs_pkg.sv
package prs_pkg;

    // one input word: a tick with its link samples
    typedef struct packed {
        logic start_req;
        logic link_connected;
        logic link_secure;
    } prs_in_t;

    // one result word per tick
    typedef struct packed {
        logic [1:0] request_count;
        logic       busy_res;
        logic       done_res;
        logic [1:0] outcome;
    } prs_out_t;

    // outcome codes
    localparam logic [1:0] PRS_OUT_OK      = 2'd0;
    localparam logic [1:0] PRS_OUT_NOCONN  = 2'd1;
    localparam logic [1:0] PRS_OUT_TIMEOUT = 2'd2;

    // register indexes
    localparam logic [1:0] PRS_REG_ROUND_LIMIT   = 2'd0;
    localparam logic [1:0] PRS_REG_POLL_INTERVAL = 2'd1;
    localparam logic [1:0] PRS_REG_REQUEST_GAP   = 2'd2;
    localparam logic [1:0] PRS_REG_ROUND_WAIT    = 2'd3;

    // register reset values
    localparam logic [7:0]  PRS_RST_ROUND_LIMIT = 8'd3;
    localparam logic [15:0] PRS_RST_ROUND_WAIT  = 16'd1000;

    // poll interval used when the register holds zero
    localparam logic [15:0] PRS_DEFAULT_POLL = 16'd20;

endpackage

FILE: src/pairing_retry_sequencer.sv
// a tick word goes through the input register, then the result register
// throughput: one tick word per cycle while out_stall is low; the state update is one
// short pass between the input register and the result register
// reset: sequencer idle, counters cleared, registers back to their defaults
`include "assert_macros.svh"

module pairing_retry_sequencer
    import prs_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  prs_in_t    in_data,
    output logic       out_valid,
    input  logic       out_stall,
    output prs_out_t   out_data,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [1:0] cfg_index,
    input  logic [15:0] cfg_data
);

    typedef enum logic [1:0] {
        PH_IDLE = 2'd0,
        PH_GAP  = 2'd1,
        PH_POLL = 2'd2,
        PH_NEXT = 2'd3
    } phase_t;

    typedef enum logic {
        AT_ROUND   = 1'b0,
        AT_POLLCHK = 1'b1
    } flow_at_t;

    // the flow inside one tick never takes more than this many steps
    localparam int FLOW_STEPS = 4;

    // configuration registers
    logic [7:0]  round_limit_reg;
    logic [15:0] poll_interval_reg;
    logic [15:0] request_gap_reg;
    logic [15:0] round_wait_reg;

    // sequencer state
    phase_t      phase_reg, phase_next;
    logic [7:0]  rounds_reg, rounds_next;
    logic [16:0] elapsed_reg, elapsed_next;
    logic [15:0] timer_reg, timer_next;

    // pipeline registers
    logic        in_vld_reg;
    prs_in_t     in_data_reg;
    logic        out_vld_reg;
    prs_out_t    out_data_reg, out_data_next;

    logic        adv;
    logic        fire;
    logic [15:0] poll_eff;

    // config port, always ready
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            round_limit_reg   <= PRS_RST_ROUND_LIMIT;
            poll_interval_reg <= '0;
            request_gap_reg   <= '0;
            round_wait_reg    <= PRS_RST_ROUND_WAIT;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                PRS_REG_ROUND_LIMIT:   round_limit_reg   <= cfg_data[7:0];
                PRS_REG_POLL_INTERVAL: poll_interval_reg <= cfg_data;
                PRS_REG_REQUEST_GAP:   request_gap_reg   <= cfg_data;
                PRS_REG_ROUND_WAIT:    round_wait_reg    <= cfg_data;
                default:               round_limit_reg   <= round_limit_reg;
            endcase
        end
    end

    // handshake: result stage moves when empty or being taken
    assign adv       = !out_vld_reg || !out_stall;
    assign fire      = in_vld_reg && adv;
    assign in_stall  = in_vld_reg && !adv;
    assign out_valid = out_vld_reg;
    assign out_data  = out_data_reg;

    assign poll_eff = (poll_interval_reg == '0) ? PRS_DEFAULT_POLL : poll_interval_reg;

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg <= 1'b0;
        end
        else if (!in_stall)
        begin
            in_vld_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!in_stall)
        begin
            in_data_reg <= in_data;
        end
    end

    // one tick of the sequencer
    always_comb
    begin
        phase_t      ph;
        logic [7:0]  rd;
        logic [16:0] el;
        logic [15:0] tmr;
        logic [1:0]  req;
        logic [1:0]  res;
        logic        fin;
        logic        run;
        flow_at_t    at;
        logic        conn;
        logic        sec;

        ph   = phase_reg;
        rd   = rounds_reg;
        el   = elapsed_reg;
        tmr  = timer_reg;
        req  = 2'd0;
        res  = PRS_OUT_OK;
        fin  = 1'b0;
        run  = 1'b0;
        at   = AT_ROUND;
        conn = in_data_reg.link_connected;
        sec  = in_data_reg.link_secure;

        // entry point by phase
        case (phase_reg)
            PH_IDLE:
            begin
                if (in_data_reg.start_req)
                begin
                    if (sec)
                    begin
                        fin = 1'b1;
                        res = PRS_OUT_OK;
                    end
                    else
                    begin
                        rd  = '0;
                        el  = '0;
                        run = 1'b1;
                        at  = AT_ROUND;
                    end
                end
            end
            PH_NEXT:
            begin
                run = 1'b1;
                at  = AT_ROUND;
            end
            default:
            begin
                if (tmr > 16'd1)
                begin
                    tmr = tmr - 16'd1;
                end
                else
                begin
                    tmr = '0;
                    if (phase_reg == PH_GAP)
                    begin
                        req = 2'(req + 2'd1);
                        el  = '0;
                    end
                    run = 1'b1;
                    at  = AT_POLLCHK;
                end
            end
        endcase

        // zero-time flow: round start and status checks
        for (int i = 0; i < FLOW_STEPS; i++)
        begin
            if (run)
            begin
                if (at == AT_ROUND)
                begin
                    if (rd >= round_limit_reg)
                    begin
                        fin = 1'b1;
                        run = 1'b0;
                        res = !conn ? PRS_OUT_NOCONN : (sec ? PRS_OUT_OK : PRS_OUT_TIMEOUT);
                    end
                    else if (!conn)
                    begin
                        fin = 1'b1;
                        run = 1'b0;
                        res = PRS_OUT_NOCONN;
                    end
                    else
                    begin
                        req = 2'(req + 2'd1);
                        if (request_gap_reg != '0)
                        begin
                            tmr = request_gap_reg;
                            ph  = PH_GAP;
                            run = 1'b0;
                        end
                        else
                        begin
                            req = 2'(req + 2'd1);
                            el  = '0;
                            at  = AT_POLLCHK;
                        end
                    end
                end
                else
                begin
                    if (el < {1'b0, round_wait_reg})
                    begin
                        run = 1'b0;
                        if (!conn)
                        begin
                            fin = 1'b1;
                            res = PRS_OUT_NOCONN;
                        end
                        else if (sec)
                        begin
                            fin = 1'b1;
                            res = PRS_OUT_OK;
                        end
                        else
                        begin
                            tmr = poll_eff;
                            el  = 17'(el + {1'b0, poll_eff});
                            ph  = PH_POLL;
                        end
                    end
                    else if (sec)
                    begin
                        fin = 1'b1;
                        run = 1'b0;
                        res = PRS_OUT_OK;
                    end
                    else
                    begin
                        rd = 8'(rd + 8'd1);
                        if (req != 2'd0 && rd < round_limit_reg)
                        begin
                            ph  = PH_NEXT;
                            run = 1'b0;
                        end
                        else
                        begin
                            at = AT_ROUND;
                        end
                    end
                end
            end
        end

        if (fin)
        begin
            ph  = PH_IDLE;
            tmr = '0;
        end

        phase_next   = ph;
        rounds_next  = rd;
        elapsed_next = el;
        timer_next   = tmr;

        out_data_next.request_count = req;
        out_data_next.busy_res      = (ph != PH_IDLE);
        out_data_next.done_res      = fin;
        out_data_next.outcome       = fin ? res : PRS_OUT_OK;
    end

    // state and result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_IDLE;
            rounds_reg  <= '0;
            elapsed_reg <= '0;
            timer_reg   <= '0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            if (adv)
            begin
                out_vld_reg <= in_vld_reg;
            end
            if (fire)
            begin
                phase_reg   <= phase_next;
                rounds_reg  <= rounds_next;
                elapsed_reg <= elapsed_next;
                timer_reg   <= timer_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            out_data_reg <= out_data_next;
        end
    end

    // checks
    `ASSERT_IMPLIES(a_done_not_busy, out_vld_reg && out_data_reg.done_res,
        !out_data_reg.busy_res, "finished sequence still reports busy")
    `ASSERT_IMPLIES(a_req_range, out_vld_reg, out_data_reg.request_count != 2'd3,
        "more than two pairing requests in one tick")
    `ASSERT_IMPLIES(a_outcome_with_done, out_vld_reg && !out_data_reg.done_res,
        out_data_reg.outcome == PRS_OUT_OK, "outcome set without done")
    `ASSERT_NEXT(a_idle_after_free, fire && !out_data_next.busy_res,
        phase_reg == PH_IDLE, "sequencer not idle after a non-busy result")

endmodule

FILE: test/pairing_retry_sequencer_tb.sv
`timescale 1ns / 1ps

module pairing_retry_sequencer_tb;
    import prs_pkg::*;

    localparam int WATCHDOG_LIMIT = 4000;
    localparam int DRAIN_PAD      = 6;
    localparam int RANDOM_PHASES  = 8;
    localparam int TICKS_PER_PHASE = 55;

    typedef enum logic [1:0] {
        SEQ_IDLE = 2'd0,
        SEQ_GAP  = 2'd1,
        SEQ_POLL = 2'd2,
        SEQ_NEXT = 2'd3
    } seq_phase_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    prs_in_t     in_data = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    prs_out_t    out_data;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_index = '0;
    logic [15:0] cfg_data = '0;

    // tick words waiting to be sent and results owed by the block
    prs_in_t  ticks_pending[$];
    prs_out_t results_due[$];

    int  ticks_queued = 0;
    int  ticks_taken = 0;
    int  results_seen = 0;
    int  reg_writes = 0;
    int  mismatches = 0;
    int  ended_ok = 0;
    int  ended_noconn = 0;
    int  ended_timeout = 0;
    int  idle_cycles = 0;
    bit  quiet = 1'b0;

    // shadow registers
    logic [7:0]  round_cap = PRS_RST_ROUND_LIMIT;
    logic [15:0] poll_step = '0;
    logic [15:0] pair_gap  = '0;
    logic [15:0] poll_span = PRS_RST_ROUND_WAIT;

    // shadow sequencer state
    seq_phase_t  seq_ph = SEQ_IDLE;
    logic [7:0]  rounds_run = '0;
    logic [16:0] polled_ticks = '0;
    logic [15:0] ticks_left = '0;

    pairing_retry_sequencer uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #5 clk = ~clk;

    // mostly short gaps, a few long ones, none in quiet stretches
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (quiet || r < 60)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(4, 20);
    endfunction

    // advance the sequencer by one tick and return the result word
    function automatic prs_out_t advance_sequencer(prs_in_t w);
        logic [1:0]  req;
        logic [1:0]  res;
        logic [15:0] step;
        bit          fin;
        bit          running;
        bit          at_round;
        prs_out_t    r;
        req = '0;
        res = PRS_OUT_OK;
        fin = 1'b0;
        running = 1'b0;
        at_round = 1'b0;
        case (seq_ph)
            SEQ_IDLE:
            begin
                if (w.start_req)
                begin
                    if (w.link_secure)
                        fin = 1'b1;
                    else
                    begin
                        rounds_run = '0;
                        polled_ticks = '0;
                        at_round = 1'b1;
                        running = 1'b1;
                    end
                end
            end
            SEQ_NEXT:
            begin
                at_round = 1'b1;
                running = 1'b1;
            end
            default:
            begin
                if (ticks_left > 16'd1)
                    ticks_left = ticks_left - 16'd1;
                else
                begin
                    ticks_left = '0;
                    if (seq_ph == SEQ_GAP)
                    begin
                        req = req + 2'd1;
                        polled_ticks = '0;
                    end
                    running = 1'b1;
                end
            end
        endcase

        // zero-time flow: round entry and poll checks
        while (running)
        begin
            if (at_round)
            begin
                if (rounds_run >= round_cap)
                begin
                    running = 1'b0;
                    fin = 1'b1;
                    if (!w.link_connected)
                        res = PRS_OUT_NOCONN;
                    else if (w.link_secure)
                        res = PRS_OUT_OK;
                    else
                        res = PRS_OUT_TIMEOUT;
                end
                else if (!w.link_connected)
                begin
                    running = 1'b0;
                    fin = 1'b1;
                    res = PRS_OUT_NOCONN;
                end
                else
                begin
                    req = req + 2'd1;
                    if (pair_gap != 16'd0)
                    begin
                        ticks_left = pair_gap;
                        seq_ph = SEQ_GAP;
                        running = 1'b0;
                    end
                    else
                    begin
                        req = req + 2'd1;
                        polled_ticks = '0;
                        at_round = 1'b0;
                    end
                end
            end
            else if (polled_ticks < {1'b0, poll_span})
            begin
                step = (poll_step == 16'd0) ? PRS_DEFAULT_POLL : poll_step;
                running = 1'b0;
                if (!w.link_connected)
                begin
                    fin = 1'b1;
                    res = PRS_OUT_NOCONN;
                end
                else if (w.link_secure)
                begin
                    fin = 1'b1;
                    res = PRS_OUT_OK;
                end
                else
                begin
                    ticks_left = step;
                    polled_ticks = polled_ticks + {1'b0, step};
                    seq_ph = SEQ_POLL;
                end
            end
            else if (w.link_secure)
            begin
                running = 1'b0;
                fin = 1'b1;
                res = PRS_OUT_OK;
            end
            else
            begin
                rounds_run = rounds_run + 8'd1;
                if (req != 2'd0 && rounds_run < round_cap)
                begin
                    seq_ph = SEQ_NEXT;
                    running = 1'b0;
                end
                else
                    at_round = 1'b1;
            end
        end

        if (fin)
        begin
            seq_ph = SEQ_IDLE;
            ticks_left = '0;
        end
        r.request_count = req;
        r.busy_res = (seq_ph != SEQ_IDLE);
        r.done_res = fin;
        r.outcome = fin ? res : PRS_OUT_OK;
        return r;
    endfunction

    // driver: present queued tick words, predict on acceptance
    int send_hold = 0;
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            in_data <= '0;
            send_hold = 0;
        end
        else
        begin
            if (in_valid && !in_stall)
            begin
                results_due.push_back(advance_sequencer(in_data));
                ticks_taken++;
            end
            if (!in_valid || !in_stall)
            begin
                if (send_hold > 0)
                begin
                    send_hold--;
                    in_valid <= 1'b0;
                end
                else if (ticks_pending.size() > 0)
                begin
                    in_data <= ticks_pending.pop_front();
                    in_valid <= 1'b1;
                    send_hold = pick_gap();
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // monitor: random stalls, compare each result word with the oldest due
    int stall_left = 0;
    always @(posedge clk or negedge rst_n)
    begin
        prs_out_t want;
        if (!rst_n)
        begin
            out_stall <= 1'b0;
            stall_left = 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                results_seen++;
                if (results_due.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("result word %0d arrived with none due: %p",
                                 results_seen, out_data);
                end
                else
                begin
                    want = results_due.pop_front();
                    if (want.done_res)
                    begin
                        if (want.outcome == PRS_OUT_OK)
                            ended_ok++;
                        else if (want.outcome == PRS_OUT_NOCONN)
                            ended_noconn++;
                        else
                            ended_timeout++;
                    end
                    if (out_data.request_count !== want.request_count ||
                        out_data.busy_res !== want.busy_res ||
                        out_data.done_res !== want.done_res ||
                        out_data.outcome !== want.outcome)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("result word %0d: expected %p, got %p",
                                     results_seen, want, out_data);
                    end
                end
            end
            if (stall_left > 0)
            begin
                stall_left--;
                out_stall <= 1'b1;
            end
            else
            begin
                out_stall <= 1'b0;
                stall_left = pick_gap();
            end
        end
    end

    // watchdog on cycles with no word moving on any channel
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall) ||
                (cfg_valid && cfg_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("watchdog expired, %0d results still due", results_due.size());
                $display("FAIL pairing_retry_sequencer");
                $finish;
            end
        end
    end

    task automatic send_tick(bit start, bit conn, bit sec);
        prs_in_t w;
        w.start_req = start;
        w.link_connected = conn;
        w.link_secure = sec;
        ticks_pending.push_back(w);
        ticks_queued++;
    endtask

    task automatic wait_taken();
        while (ticks_taken != ticks_queued)
            @(posedge clk);
    endtask

    task automatic wait_idle();
        while (ticks_taken != ticks_queued || results_due.size() != 0)
            @(posedge clk);
        repeat (DRAIN_PAD) @(posedge clk);
    endtask

    // feed secure ticks until the running sequence closes
    task automatic close_sequence();
        wait_taken();
        while (seq_ph != SEQ_IDLE)
        begin
            send_tick(1'b0, 1'b1, 1'b1);
            wait_taken();
        end
        wait_idle();
    endtask

    task automatic write_reg(logic [1:0] idx, logic [15:0] val);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do
            @(posedge clk);
        while (!(cfg_valid && cfg_ready));
        cfg_valid <= 1'b0;
        reg_writes++;
        case (idx)
            PRS_REG_ROUND_LIMIT:   round_cap = val[7:0];
            PRS_REG_POLL_INTERVAL: poll_step = val;
            PRS_REG_REQUEST_GAP:   pair_gap = val;
            PRS_REG_ROUND_WAIT:    poll_span = val;
        endcase
    endtask

    task automatic program_regs(logic [7:0] lim, logic [15:0] poll, logic [15:0] gap,
                                logic [15:0] span);
        write_reg(PRS_REG_ROUND_LIMIT, {8'd0, lim});
        write_reg(PRS_REG_POLL_INTERVAL, poll);
        write_reg(PRS_REG_REQUEST_GAP, gap);
        write_reg(PRS_REG_ROUND_WAIT, span);
    endtask

    initial
    begin
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // reset defaults: plain tick, secure start, unconnected start, a running one, two more ticks
        quiet = 1'b1;
        send_tick(1'b0, 1'b1, 1'b0);
        send_tick(1'b1, 1'b1, 1'b1);
        send_tick(1'b1, 1'b0, 1'b0);
        send_tick(1'b1, 1'b1, 1'b0);
        send_tick(1'b1, 1'b0, 1'b1);
        send_tick(1'b0, 1'b0, 1'b0);
        close_sequence();

        // zero rounds with every other register at its top
        quiet = 1'b0;
        program_regs(8'd0, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        send_tick(1'b1, 1'b1, 1'b0);
        send_tick(1'b1, 1'b0, 1'b0);
        send_tick(1'b1, 1'b0, 1'b1);
        wait_idle();

        // most rounds, one-tick gap, the check after the gap decides
        program_regs(8'd255, 16'hFFFF, 16'd1, 16'hFFFF);
        send_tick(1'b1, 1'b1, 1'b0);
        send_tick(1'b0, 1'b1, 1'b1);
        send_tick(1'b1, 1'b1, 1'b0);
        send_tick(1'b0, 1'b0, 1'b0);
        wait_idle();

        // zero round wait: rounds follow one per tick until exhausted
        program_regs(8'd4, 16'd0, 16'd0, 16'd0);
        send_tick(1'b1, 1'b1, 1'b0);
        repeat (3) send_tick(1'b0, 1'b1, 1'b0);
        send_tick(1'b1, 1'b1, 1'b0);
        send_tick(1'b0, 1'b1, 1'b1);
        close_sequence();

        // random phases with small settings so sequences run to the end
        for (int ph = 0; ph < RANDOM_PHASES; ph++)
        begin
            program_regs(8'($urandom_range(0, 6)), 16'($urandom_range(0, 5)),
                         16'($urandom_range(0, 4)), 16'($urandom_range(0, 30)));
            quiet = ($urandom_range(0, 3) == 0);
            for (int i = 0; i < TICKS_PER_PHASE; i++)
                send_tick($urandom_range(0, 9) < 3, $urandom_range(0, 19) != 0,
                          $urandom_range(0, 9) == 0);
            close_sequence();
        end

        wait_idle();
        $display("%0d tick words over %0d register writes, with gaps and stalls on both sides",
                 ticks_taken, reg_writes);
        $display("sequences closed: %0d ok, %0d not connected, %0d timed out",
                 ended_ok, ended_noconn, ended_timeout);
        if (mismatches == 0 && results_due.size() == 0)
            $display("PASS pairing_retry_sequencer");
        else
            $display("FAIL pairing_retry_sequencer");
        $finish;
    end

endmodule
